### hdl/pcd_pkg.sv
// Shared types and constants for the point-to-cylinder distance block.
// No dependencies; point_cylinder_distance_top and pcd_checker import this package.
`default_nettype none
package pcd_pkg;

  localparam int PCD_COORD_BITS = 32;
  localparam int PCD_FRAC_BITS  = 8;
  localparam int PCD_FIELD_W    = 32;
  localparam int PCD_DIST_W     = 64;
  localparam int PCD_CFG_IDX_W  = 3;
  localparam int PCD_CFG_DATA_W = 32;

  // Register reset values (axis along z, radius 1.0, height 2.0 in Q.8)
  localparam int PCD_RST_AXIS_Z = 256;
  localparam int PCD_RST_RADIUS = 256;
  localparam int PCD_RST_HEIGHT = 512;

  typedef enum logic [PCD_CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_AXIS_X   = 3'd3,
    CFG_AXIS_Y   = 3'd4,
    CFG_AXIS_Z   = 3'd5,
    CFG_RADIUS   = 3'd6,
    CFG_HEIGHT   = 3'd7
  } pcd_cfg_idx_t;

  typedef struct packed {
    logic signed [PCD_FIELD_W-1:0] pos_x;
    logic signed [PCD_FIELD_W-1:0] pos_y;
    logic signed [PCD_FIELD_W-1:0] pos_z;
  } pcd_req_t;

  typedef struct packed {
    logic [PCD_DIST_W-1:0] dist_sq;
    logic                  inside_res;
    logic                  axis_zero;
  } pcd_res_t;

endpackage
`default_nettype wire

### hdl/point_cylinder_distance_top.sv
// Squared distance from a stream of points to a solid cylinder held in registers.
// Depends on pcd_pkg, pcd_front, pcd_isqrt and pcd_div.
//
// Channels: a request is taken at each rising edge with start high; busy is
// always low, so one point may be offered in every cycle. Each result appears
// on res for a single cycle with done high; it must be taken then.
// Registers are written through cfg_we / cfg_index / cfg_data, one per edge; the
// user must write them while no request is in flight; the block does not enforce it.
// Throughput: one point per cycle. The pipeline consists of the bit-per-stage
// square root of |A|^2 (COORD_BITS stages), the bit-per-stage divider for the
// axial distance (COORD_BITS+2 stages) and the square root of the radial term
// (COORD_BITS+1 stages), plus ten stages of multiply, add and compare.
// Reset: clears every in-flight request and loads the default cylinder
// (centre at the origin, axis along z, radius 1.0, height 2.0).
// A zero axis gives axis_zero with a zero distance; inside points give zero.
`default_nettype none
module point_cylinder_distance_top
  import pcd_pkg::*;
#(
  parameter int COORD_BITS = PCD_COORD_BITS,
  parameter int FRAC_BITS  = PCD_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  pcd_req_t                  req,
  output logic                      done,
  output pcd_res_t                  res,
  input  logic                      cfg_we,
  input  logic [PCD_CFG_IDX_W-1:0]  cfg_index,
  input  logic [PCD_CFG_DATA_W-1:0] cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int QW    = C + 2;
  localparam int TOT_W = 2 * C + 5;
  localparam int SCW   = (TOT_W + 16 > PCD_DIST_W) ? TOT_W + 16 : PCD_DIST_W + 1;
  localparam int S1W   = (2 * C + 2) + (2 * C + 1) + 1;
  localparam int S2W   = (2 * C + 2) + 1;
  localparam int S3W   = 3 + (2 * C + 4);

  // Configuration registers
  logic [C-1:0] cen [3];
  logic [C-1:0] ax  [3];
  logic [C-2:0] radius;
  logic [C-1:0] height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cen[0] <= '0;
      cen[1] <= '0;
      cen[2] <= '0;
      ax[0]  <= '0;
      ax[1]  <= '0;
      ax[2]  <= C'(PCD_RST_AXIS_Z);
      radius <= (C-1)'(PCD_RST_RADIUS);
      height <= C'(PCD_RST_HEIGHT);
    end else if (cfg_we) begin
      unique case (pcd_cfg_idx_t'(cfg_index))
        CFG_CENTER_X: cen[0] <= C'($signed(cfg_data));
        CFG_CENTER_Y: cen[1] <= C'($signed(cfg_data));
        CFG_CENTER_Z: cen[2] <= C'($signed(cfg_data));
        CFG_AXIS_X:   ax[0]  <= C'($signed(cfg_data));
        CFG_AXIS_Y:   ax[1]  <= C'($signed(cfg_data));
        CFG_AXIS_Z:   ax[2]  <= C'($signed(cfg_data));
        CFG_RADIUS:   radius <= (C-1)'(cfg_data[PCD_CFG_DATA_W-2:0]);
        CFG_HEIGHT:   height <= C'(cfg_data);
      endcase
    end
  end

  assign busy = 1'b0;

  logic [C-1:0] pos [3];
  assign pos[0] = C'($signed(req.pos_x));
  assign pos[1] = C'($signed(req.pos_y));
  assign pos[2] = C'($signed(req.pos_z));

  // Front end
  logic           fr_valid;
  logic [2*C-1:0] fr_l2;
  logic [2*C+1:0] fr_d2;
  logic [2*C:0]   fr_adot;
  logic           fr_zero;

  pcd_front #(.C(C)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .cen       (cen),
    .ax        (ax),
    .pos       (pos),
    .out_valid (fr_valid),
    .l2        (fr_l2),
    .d2        (fr_d2),
    .adot      (fr_adot),
    .axis_zero (fr_zero)
  );

  // Axis length
  logic           sq1_valid;
  logic [C-1:0]   sq1_len;
  logic [S1W-1:0] sq1_side;
  logic [2*C+1:0] sq1_d2;
  logic [2*C:0]   sq1_adot;
  logic           sq1_zero;

  pcd_isqrt #(.NW(2 * C), .SW(S1W)) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .radicand  (fr_l2),
    .side_in   ({fr_d2, fr_adot, fr_zero}),
    .out_valid (sq1_valid),
    .root      (sq1_len),
    .side_out  (sq1_side)
  );

  assign {sq1_d2, sq1_adot, sq1_zero} = sq1_side;

  // Axial distance x = |D.A| / len
  logic           dv_valid;
  logic [QW-1:0]  dv_x;
  logic [S2W-1:0] dv_side;
  logic [2*C+1:0] dv_d2;
  logic           dv_zero;

  pcd_div #(.NW(2 * C + 1), .DW(C), .QW(QW), .SW(S2W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq1_valid),
    .dividend  (sq1_adot),
    .divisor   (sq1_len),
    .side_in   ({sq1_d2, sq1_zero}),
    .out_valid (dv_valid),
    .quotient  (dv_x),
    .side_out  (dv_side)
  );

  assign {dv_d2, dv_zero} = dv_side;

  // M1: x^2
  logic           m1_valid;
  logic [2*C+3:0] m1_x2;
  logic [QW-1:0]  m1_x;
  logic [2*C+1:0] m1_d2;
  logic           m1_zero;
  // M2: radial term, height test, cap offset, radius^2
  logic           m2_valid;
  logic [2*C+1:0] m2_y2;
  logic           m2_in_h;
  logic [C+2:0]   m2_e;
  logic [2*C-3:0] m2_r2;
  logic           m2_zero;
  // M3: radius test, cap term
  logic           m3_valid;
  logic [2*C+1:0] m3_y2;
  logic           m3_in_h;
  logic           m3_in_r;
  logic [2*C+3:0] m3_cap;
  logic           m3_zero;

  logic [2*C+5:0] e_sq;
  assign e_sq = (2*C+6)'(m2_e) * (2*C+6)'(m2_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else begin
      m1_valid <= dv_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_x2   <= (2*C+4)'(dv_x) * (2*C+4)'(dv_x);
    m1_x    <= dv_x;
    m1_d2   <= dv_d2;
    m1_zero <= dv_zero;

    // clamp the radial term at zero
    m2_y2   <= ((2*C+4)'(m1_d2) >= m1_x2) ? (m1_d2 - m1_x2[2*C+1:0]) : '0;
    m2_in_h <= (m1_x <= QW'(height >> 1));
    m2_e    <= (C+3)'({m1_x, 1'b0}) - (C+3)'(height);
    m2_r2   <= (2*C-2)'(radius) * (2*C-2)'(radius);
    m2_zero <= m1_zero;

    m3_y2   <= m2_y2;
    m3_in_h <= m2_in_h;
    m3_in_r <= (m2_y2 <= (2*C+2)'(m2_r2));
    m3_cap  <= e_sq[2*C+5:2];
    m3_zero <= m2_zero;
  end

  // Radial distance from the axis
  logic           sq2_valid;
  logic [C:0]     sq2_s;
  logic [S3W-1:0] sq2_side;
  logic           sq2_in_r;
  logic           sq2_in_h;
  logic [2*C+3:0] sq2_cap;
  logic           sq2_zero;

  pcd_isqrt #(.NW(2 * C + 2), .SW(S3W)) u_rad_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m3_valid),
    .radicand  (m3_y2),
    .side_in   ({m3_in_r, m3_in_h, m3_cap, m3_zero}),
    .out_valid (sq2_valid),
    .root      (sq2_s),
    .side_out  (sq2_side)
  );

  assign {sq2_in_r, sq2_in_h, sq2_cap, sq2_zero} = sq2_side;

  // T1: side offset, T2: its square, T3: sum, scale, saturate
  logic           t1_valid;
  logic [C:0]     t1_t;
  logic           t1_in_r;
  logic           t1_in_h;
  logic [2*C+3:0] t1_cap;
  logic           t1_zero;
  logic           t2_valid;
  logic [2*C+1:0] t2_side;
  logic           t2_in_r;
  logic           t2_in_h;
  logic [2*C+3:0] t2_cap;
  logic           t2_zero;
  logic           t3_valid;
  pcd_res_t       t3_res;

  logic [TOT_W-1:0] total;
  logic [SCW-1:0]   scaled;
  logic             sat;

  assign total  = (t2_in_r ? TOT_W'(0) : TOT_W'(t2_side))
                + (t2_in_h ? TOT_W'(0) : TOT_W'(t2_cap));
  assign scaled = (SCW'(total) << 16) >> (2 * FRAC_BITS);
  assign sat    = |scaled[SCW-1:PCD_DIST_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
      t2_valid <= 1'b0;
      t3_valid <= 1'b0;
    end else begin
      t1_valid <= sq2_valid;
      t2_valid <= t1_valid;
      t3_valid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    t1_t    <= (sq2_s >= (C+1)'(radius)) ? (sq2_s - (C+1)'(radius)) : '0;
    t1_in_r <= sq2_in_r;
    t1_in_h <= sq2_in_h;
    t1_cap  <= sq2_cap;
    t1_zero <= sq2_zero;

    t2_side <= (2*C+2)'(t1_t) * (2*C+2)'(t1_t);
    t2_in_r <= t1_in_r;
    t2_in_h <= t1_in_h;
    t2_cap  <= t1_cap;
    t2_zero <= t1_zero;

    if (t2_zero) begin
      t3_res.dist_sq    <= '0;
      t3_res.inside_res <= 1'b0;
      t3_res.axis_zero  <= 1'b1;
    end else if (t2_in_h && t2_in_r) begin
      t3_res.dist_sq    <= '0;
      t3_res.inside_res <= 1'b1;
      t3_res.axis_zero  <= 1'b0;
    end else begin
      t3_res.dist_sq    <= sat ? '1 : scaled[PCD_DIST_W-1:0];
      t3_res.inside_res <= 1'b0;
      t3_res.axis_zero  <= 1'b0;
    end
  end

  assign done = t3_valid;
  assign res  = t3_res;

endmodule
`default_nettype wire

### hdl/pcd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Standalone; a sideband word travels alongside each radicand.
`default_nettype none
module pcd_isqrt #(
  parameter int NW = 64,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [NW-1:0]   radicand,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [NW/2-1:0] root,
  output logic [SW-1:0]   side_out
);

  localparam int RW = NW / 2;

  logic          vld_q  [RW];
  logic [NW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int B = RW - 1 - g;
    logic          v_i;
    logic [NW-1:0] rem_i;
    logic [RW-1:0] root_i;
    logic [SW-1:0] side_i;
    logic [NW:0]   trial;
    logic          take;

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = radicand;
      assign root_i = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign v_i    = vld_q[g-1];
      assign rem_i  = rem_q[g-1];
      assign root_i = root_q[g-1];
      assign side_i = side_q[g-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = ((NW+1)'(root_i) << (B + 1)) + ((NW+1)'(1) << (2 * B));
    assign take  = ((NW+1)'(rem_i) >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[g]  <= take ? (rem_i - trial[NW-1:0]) : rem_i;
      root_q[g] <= take ? (root_i | (RW'(1) << B)) : root_i;
      side_q[g] <= side_i;
    end
  end

  assign out_valid = vld_q[RW-1];
  assign root      = root_q[RW-1];
  assign side_out  = side_q[RW-1];

endmodule
`default_nettype wire

### hdl/pcd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; the quotient must fit QW bits, a sideband word travels along.
`default_nettype none
module pcd_div #(
  parameter int NW = 65,
  parameter int DW = 32,
  parameter int QW = 34,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic [SW-1:0] side_out
);

  localparam int TW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic          vld_q  [QW];
  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] dvs_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int B = QW - 1 - g;
    logic          v_i;
    logic [NW-1:0] rem_i;
    logic [DW-1:0] dvs_i;
    logic [QW-1:0] quo_i;
    logic [SW-1:0] side_i;
    logic [TW-1:0] trial;
    logic          take;

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = dividend;
      assign dvs_i  = divisor;
      assign quo_i  = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign v_i    = vld_q[g-1];
      assign rem_i  = rem_q[g-1];
      assign dvs_i  = dvs_q[g-1];
      assign quo_i  = quo_q[g-1];
      assign side_i = side_q[g-1];
    end

    assign trial = TW'(dvs_i) << B;
    assign take  = (TW'(rem_i) >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[g]  <= take ? (rem_i - trial[NW-1:0]) : rem_i;
      quo_q[g]  <= take ? (quo_i | (QW'(1) << B)) : quo_i;
      dvs_q[g]  <= dvs_i;
      side_q[g] <= side_i;
    end
  end

  assign out_valid = vld_q[QW-1];
  assign quotient  = quo_q[QW-1];
  assign side_out  = side_q[QW-1];

endmodule
`default_nettype wire

### hdl/pcd_front.sv
// Front end: offset from the centre, products and sums of |A|^2, |D|^2, |D.A|.
// Four register stages; standalone arithmetic on COORD_BITS-wide vectors.
`default_nettype none
module pcd_front #(
  parameter int C = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [C-1:0]   cen [3],
  input  logic [C-1:0]   ax  [3],
  input  logic [C-1:0]   pos [3],
  output logic           out_valid,
  output logic [2*C-1:0] l2,
  output logic [2*C+1:0] d2,
  output logic [2*C:0]   adot,
  output logic           axis_zero
);

  logic [3:0] vld_q;

  logic [C:0]     dm_c [3];
  logic [C-1:0]   am_c [3];
  logic           ng_c [3];
  logic [C:0]     dm_q [3];
  logic [C-1:0]   am_q [3];
  logic           ng_q [3];
  logic           ng2_q [3];
  logic [2*C:0]   pd_q [3];
  logic [2*C-1:0] pa_q [3];
  logic [2*C+1:0] pdd_q [3];
  logic [2*C-1:0] l2_q;
  logic [2*C+1:0] d2_q;
  logic [2*C:0]   pos_q;
  logic [2*C:0]   neg_q;
  logic [2*C-1:0] l2_o;
  logic [2*C+1:0] d2_o;
  logic [2*C:0]   adot_o;
  logic           zero_o;

  always_comb begin
    logic signed [C:0]   d;
    logic signed [C-1:0] a;
    for (int i = 0; i < 3; i++) begin
      d       = $signed({cen[i][C-1], cen[i]}) - $signed({pos[i][C-1], pos[i]});
      a       = $signed(ax[i]);
      dm_c[i] = d[C] ? (C+1)'(-d) : (C+1)'(d);
      am_c[i] = a[C-1] ? C'(-a) : C'(a);
      ng_c[i] = d[C] ^ a[C-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    logic [2*C:0] ps;
    logic [2*C:0] ns;
    ps = '0;
    ns = '0;
    for (int i = 0; i < 3; i++) begin
      dm_q[i]  <= dm_c[i];
      am_q[i]  <= am_c[i];
      ng_q[i]  <= ng_c[i];
      pd_q[i]  <= (2*C+1)'(dm_q[i]) * (2*C+1)'(am_q[i]);
      pa_q[i]  <= (2*C)'(am_q[i]) * (2*C)'(am_q[i]);
      pdd_q[i] <= (2*C+2)'(dm_q[i]) * (2*C+2)'(dm_q[i]);
      ng2_q[i] <= ng_q[i];
      if (ng2_q[i]) begin
        ns = ns + pd_q[i];
      end else begin
        ps = ps + pd_q[i];
      end
    end
    l2_q  <= pa_q[0] + pa_q[1] + pa_q[2];
    d2_q  <= pdd_q[0] + pdd_q[1] + pdd_q[2];
    pos_q <= ps;
    neg_q <= ns;
    l2_o   <= l2_q;
    d2_o   <= d2_q;
    adot_o <= (pos_q >= neg_q) ? (pos_q - neg_q) : (neg_q - pos_q);
    zero_o <= (l2_q == '0);
  end

  assign out_valid = vld_q[3];
  assign l2        = l2_o;
  assign d2        = d2_o;
  assign adot      = adot_o;
  assign axis_zero = zero_o;

endmodule
`default_nettype wire

### hdl/pcd_checker.sv
// Port-level checks for point_cylinder_distance_top, attached by bind.
// Depends on pcd_pkg for the result struct.
`default_nettype none
module pcd_checker
  import pcd_pkg::*;
#(
  parameter int COORD_BITS = PCD_COORD_BITS
) (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input pcd_res_t res
);

  localparam int LAT = 3 * COORD_BITS + 13;

  // every accepted request comes back after the fixed latency
  a_req_to_res: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request not answered after fixed latency");

  // no result without a request that latency ago
  a_res_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  a_zero_axis: assert property (@(posedge clk) disable iff (rst)
    (done && res.axis_zero) |-> (res.dist_sq == '0 && !res.inside_res))
    else $error("zero axis with non-zero outputs");

  a_inside: assert property (@(posedge clk) disable iff (rst)
    (done && res.inside_res) |-> (res.dist_sq == '0))
    else $error("inside point with non-zero distance");

endmodule

bind point_cylinder_distance_top pcd_checker #(.COORD_BITS(COORD_BITS)) u_pcd_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);
`default_nettype wire
